@@ rtl/scope_minmax_column_decimator_defines.svh @@
// Assertion macros for the scope min/max column decimator checker.
// Used by scd_checker.sv; expects signals named clk and rst_n in scope.
`ifndef SCOPE_MINMAX_COLUMN_DECIMATOR_DEFINES_SVH
`define SCOPE_MINMAX_COLUMN_DECIMATOR_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define SCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define SCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// What must hold in the cycle after a reset edge.
`define SCD_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

@@ rtl/scd_pkg.sv @@
// Shared types and constants of the scope min/max column decimator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int NUM_BANDS  = 4;
  localparam int IN_PAIRS   = 4;
  localparam int LANES      = (NUM_BANDS < IN_PAIRS) ? NUM_BANDS : IN_PAIRS;
  localparam int BAND_W     = 2;
  localparam int CNT_W      = 3;
  localparam int SPC_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // queue depths, powers of two
  localparam int SNAP_DEPTH = 2;
  localparam int SNAP_PTR_W = $clog2(SNAP_DEPTH);
  localparam int SNAP_CNT_W = $clog2(SNAP_DEPTH + 1);
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [15:0] MARGIN_Q4 = 16'd224;
  localparam logic signed [15:0] EMPTY_MIN = 16'sh7FFF;
  localparam logic signed [15:0] EMPTY_MAX = -16'sh8000;

  // row = round(N / (25 * 2^20)); the half step is 400 in units of 2^15
  localparam logic [23:0] HALF_Q15    = 24'd400;
  localparam logic [19:0] DIV25_MUL   = 20'd671089;
  localparam int          DIV25_SHIFT = 24;

  typedef enum logic [1:0] {
    CMD_SAMPLE     = 2'd0,
    CMD_CLEAR_BAND = 2'd1,
    CMD_RESET_ALL  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_MID   = 2'd2,
    MODE_SIDE  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPC          = 3'd0,
    REG_BAND_COUNT   = 3'd1,
    REG_BAND_MODES   = 3'd2,
    REG_LANE_HEIGHT  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         band_select;
    logic signed [15:0] left_0;
    logic signed [15:0] right_0;
    logic signed [15:0] left_1;
    logic signed [15:0] right_1;
    logic signed [15:0] left_2;
    logic signed [15:0] right_2;
    logic signed [15:0] left_3;
    logic signed [15:0] right_3;
  } in_t;

  typedef struct packed {
    logic [1:0]         out_band;
    logic               has_data;
    logic signed [15:0] min_value;
    logic signed [15:0] max_value;
    logic [11:0]        top_pixel;
    logic [11:0]        bottom_pixel;
    logic               last_band;
  } out_t;

  // closed column handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0]            count;
    logic [LANES-1:0][15:0]      vmin;
    logic [LANES-1:0][15:0]      vmax;
  } snap_t;

  // display geometry the back end needs
  typedef struct packed {
    logic [15:0] lane_height;
    logic [11:0] image_height;
  } geom_t;

endpackage

@@ rtl/scd_front.sv @@
// Front end: configuration registers, per-band min/max tracking and column counter.
// Depends on scd_pkg; pushes closed columns into scd_snap_q.
`timescale 1ns / 1ps

module scd_front
  import scd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_t                   in_data,
  output logic                  in_full,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  snap_full,
  output logic                  snap_push,
  output snap_t                 snap_data,
  output geom_t                 geom
);

  logic [SPC_W-1:0] spc_r, spc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       modes_r, modes_nxt;
  logic [15:0]      lane_r, lane_nxt;
  logic [11:0]      img_r, img_nxt;
  logic [31:0]      prog_r, prog_nxt;

  logic signed [15:0] min_r [LANES];
  logic signed [15:0] min_nxt [LANES];
  logic signed [15:0] max_r [LANES];
  logic signed [15:0] max_nxt [LANES];
  logic signed [15:0] upd_min [LANES];
  logic signed [15:0] upd_max [LANES];
  logic signed [15:0] shown [LANES];
  logic signed [15:0] lefts [IN_PAIRS];
  logic signed [15:0] rights [IN_PAIRS];

  logic [CNT_W-1:0] cnt_eff;
  logic [SPC_W-1:0] spc_eff;
  logic [32:0]      sum33;
  logic [32:0]      diff33;
  logic             accept;
  logic             flush;

  assign accept    = in_push && !snap_full;
  assign in_full   = snap_full;
  assign cfg_ready = 1'b1;
  assign geom.lane_height  = lane_r;
  assign geom.image_height = img_r;

  assign lefts[0]  = in_data.left_0;
  assign lefts[1]  = in_data.left_1;
  assign lefts[2]  = in_data.left_2;
  assign lefts[3]  = in_data.left_3;
  assign rights[0] = in_data.right_0;
  assign rights[1] = in_data.right_1;
  assign rights[2] = in_data.right_2;
  assign rights[3] = in_data.right_3;

  always_comb begin
    if (cnt_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cnt_r > CNT_W'(LANES)) begin
      cnt_eff = CNT_W'(LANES);
    end else begin
      cnt_eff = cnt_r;
    end
    spc_eff = (spc_r < SPC_W'(ONE_Q16)) ? SPC_W'(ONE_Q16) : spc_r;
  end

  // displayed sample per band; mid and side take the floor of the half
  always_comb begin
    logic [16:0] s_sum;
    logic [16:0] s_dif;
    for (int b = 0; b < LANES; b++) begin
      s_sum = {lefts[b][15], lefts[b]} + {rights[b][15], rights[b]};
      s_dif = {lefts[b][15], lefts[b]} - {rights[b][15], rights[b]};
      case (mode_t'(modes_r[2*b +: 2]))
        MODE_LEFT:  shown[b] = lefts[b];
        MODE_RIGHT: shown[b] = rights[b];
        MODE_MID:   shown[b] = s_sum[16:1];
        MODE_SIDE:  shown[b] = s_dif[16:1];
        default:    shown[b] = lefts[b];
      endcase
    end
  end

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      upd_min[b] = min_r[b];
      upd_max[b] = max_r[b];
      if (CNT_W'(b) < cnt_eff) begin
        if (shown[b] < min_r[b]) upd_min[b] = shown[b];
        if (shown[b] > max_r[b]) upd_max[b] = shown[b];
      end
    end
  end

  always_comb begin
    spc_nxt   = spc_r;
    cnt_nxt   = cnt_r;
    modes_nxt = modes_r;
    lane_nxt  = lane_r;
    img_nxt   = img_r;
    prog_nxt  = prog_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    snap_push = 1'b0;
    flush     = 1'b0;

    sum33  = {1'b0, prog_r} + {1'b0, ONE_Q16};
    diff33 = sum33 - {2'b0, spc_eff};

    snap_data.count = cnt_eff;
    for (int b = 0; b < LANES; b++) begin
      snap_data.vmin[b] = upd_min[b];
      snap_data.vmax[b] = upd_max[b];
    end

    if (accept) begin
      case (cmd_t'(in_data.cmd))
        CMD_SAMPLE: begin
          if (!diff33[32]) begin
            // column closes: hand the column over, start a fresh one
            prog_nxt  = diff33[31:0];
            snap_push = 1'b1;
            for (int b = 0; b < LANES; b++) begin
              min_nxt[b] = EMPTY_MIN;
              max_nxt[b] = EMPTY_MAX;
            end
          end else begin
            prog_nxt = sum33[31:0];
            min_nxt  = upd_min;
            max_nxt  = upd_max;
          end
        end
        CMD_CLEAR_BAND: begin
          if ({1'b0, in_data.band_select} < cnt_eff) begin
            for (int b = 0; b < LANES; b++) begin
              if (BAND_W'(b) == in_data.band_select) begin
                min_nxt[b] = EMPTY_MIN;
                max_nxt[b] = EMPTY_MAX;
              end
            end
          end
        end
        CMD_RESET_ALL: begin
          flush = 1'b1;
        end
        default: ;
      endcase
    end

    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SPC: begin
          spc_nxt = cfg_data[SPC_W-1:0];
          if (cfg_data[SPC_W-1:0] != spc_r) flush = 1'b1;
        end
        REG_BAND_COUNT: begin
          cnt_nxt = cfg_data[CNT_W-1:0];
          if (cfg_data[CNT_W-1:0] != cnt_r) flush = 1'b1;
        end
        REG_BAND_MODES: begin
          modes_nxt = cfg_data[7:0];
          // only bands whose mode changed lose their samples
          for (int b = 0; b < LANES; b++) begin
            if (cfg_data[2*b +: 2] != modes_r[2*b +: 2]) begin
              min_nxt[b] = EMPTY_MIN;
              max_nxt[b] = EMPTY_MAX;
            end
          end
        end
        REG_LANE_HEIGHT: begin
          lane_nxt = cfg_data[15:0];
          if (cfg_data[15:0] != lane_r) flush = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          img_nxt = cfg_data[11:0];
          if (cfg_data[11:0] != img_r) flush = 1'b1;
        end
        default: ;
      endcase
    end

    if (flush) begin
      prog_nxt = '0;
      for (int b = 0; b < LANES; b++) begin
        min_nxt[b] = EMPTY_MIN;
        max_nxt[b] = EMPTY_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r   <= SPC_W'(ONE_Q16);
      cnt_r   <= CNT_W'(1);
      modes_r <= '0;
      lane_r  <= 16'd2880;
      img_r   <= 12'd720;
      prog_r  <= '0;
      for (int b = 0; b < LANES; b++) begin
        min_r[b] <= EMPTY_MIN;
        max_r[b] <= EMPTY_MAX;
      end
    end else begin
      spc_r   <= spc_nxt;
      cnt_r   <= cnt_nxt;
      modes_r <= modes_nxt;
      lane_r  <= lane_nxt;
      img_r   <= img_nxt;
      prog_r  <= prog_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

endmodule

@@ rtl/scd_snap_q.sv @@
// Short queue of closed columns between front and back end.
// Depends on scd_pkg (snap_t, SNAP_DEPTH).
`timescale 1ns / 1ps

module scd_snap_q
  import scd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  snap_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output snap_t head
);

  snap_t                 mem_r [SNAP_DEPTH];
  logic [SNAP_PTR_W-1:0] wr_r, wr_nxt;
  logic [SNAP_PTR_W-1:0] rd_r, rd_nxt;
  logic [SNAP_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == SNAP_CNT_W'(SNAP_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + SNAP_PTR_W'(1) : wr_r;
    rd_nxt  = pop  ? rd_r + SNAP_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + SNAP_CNT_W'(push) - SNAP_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

@@ rtl/scd_back.sv @@
// Back end: walks the bands of a closed column and maps min/max to pixel rows.
// Depends on scd_pkg; reads scd_snap_q, writes scd_out_q under a credit check.
`timescale 1ns / 1ps

module scd_back
  import scd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 snap_valid,
  input  snap_t                snap_head,
  output logic                 snap_pop,
  input  geom_t                geom,
  input  logic [OUT_CNT_W-1:0] out_level,
  output logic                 res_valid,
  output out_t                 res_data
);

  localparam int STAGES = 5;
  localparam int INF_W  = $clog2(STAGES + 1);
  localparam int USE_W  = OUT_CNT_W + 1;

  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic               last;
    logic               has;
    logic signed [15:0] vmin;
    logic signed [15:0] vmax;
  } tag_t;

  logic [BAND_W-1:0] idx_r, idx_nxt;
  logic [STAGES-1:0] vld_r;
  tag_t              tag_r [STAGES];
  tag_t              tag_in;

  // lane 0 carries the maximum (top row), lane 1 the minimum
  logic [15:0]        amp1_r;
  logic [18:0]        base1_r;
  logic signed [32:0] p2_r [2];
  logic [23:0]        b25_2_r;
  logic signed [37:0] a23_3_r [2];
  logic [38:0]        hb3_r;
  logic               neg4_r [2];
  logic [19:0]        q1_4_r [2];
  logic               neg5_r [2];
  logic [15:0]        q5_r [2];

  logic              issue;
  logic              last_in;
  logic [INF_W-1:0]  inflight;
  logic [USE_W-1:0]  used;
  logic [15:0]       amp_in;
  logic [18:0]       base_in;
  logic [11:0]       hmax;
  logic [11:0]       row [2];

  assign inflight = INF_W'($countones(vld_r));
  assign used     = USE_W'(out_level) + USE_W'(inflight);
  assign issue    = snap_valid && (used < USE_W'(OUT_DEPTH));
  assign last_in  = ((CNT_W'(idx_r) + CNT_W'(1)) == snap_head.count);
  assign snap_pop = issue && last_in;

  always_comb begin
    idx_nxt = idx_r;
    if (issue) begin
      idx_nxt = last_in ? '0 : idx_r + BAND_W'(1);
    end
    tag_in.band = idx_r;
    tag_in.last = last_in;
    tag_in.vmin = snap_head.vmin[idx_r];
    tag_in.vmax = snap_head.vmax[idx_r];
    tag_in.has  = (tag_in.vmin <= tag_in.vmax);
    amp_in  = (geom.lane_height > MARGIN_Q4) ? geom.lane_height - MARGIN_Q4 : '0;
    base_in = geom.lane_height * {idx_r, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= {vld_r[STAGES-2:0], issue};
    end
  end

  // datapath: row = L*(2b+1)/32 - v*amp*23/(25*2^20), rounded half up
  always_ff @(posedge clk) begin
    tag_r[0] <= tag_in;
    for (int s = 1; s < STAGES; s++) begin
      tag_r[s] <= tag_r[s-1];
    end

    amp1_r  <= amp_in;
    base1_r <= base_in;

    p2_r[0] <= tag_r[0].vmax * $signed({1'b0, amp1_r});
    p2_r[1] <= tag_r[0].vmin * $signed({1'b0, amp1_r});
    b25_2_r <= base1_r * 24'd25;

    for (int k = 0; k < 2; k++) begin
      a23_3_r[k] <= p2_r[k] * 38'sd23;
    end
    hb3_r <= {b25_2_r + HALF_Q15, 15'b0};

    for (int k = 0; k < 2; k++) begin
      logic signed [40:0] num;
      num = $signed({2'b0, hb3_r}) - $signed({{3{a23_3_r[k][37]}}, a23_3_r[k]});
      neg4_r[k] <= num[40];
      q1_4_r[k] <= num[39:20];
    end

    for (int k = 0; k < 2; k++) begin
      logic [39:0] prod;
      prod = q1_4_r[k] * DIV25_MUL;
      neg5_r[k] <= neg4_r[k];
      q5_r[k]   <= prod[39:DIV25_SHIFT];
    end
  end

  always_comb begin
    hmax = (geom.image_height == '0) ? '0 : geom.image_height - 12'd1;
    for (int k = 0; k < 2; k++) begin
      if (neg5_r[k]) begin
        row[k] = '0;
      end else if (q5_r[k] > {4'b0, hmax}) begin
        row[k] = hmax;
      end else begin
        row[k] = q5_r[k][11:0];
      end
    end

    res_valid             = vld_r[STAGES-1];
    res_data.out_band     = tag_r[STAGES-1].band;
    res_data.has_data     = tag_r[STAGES-1].has;
    res_data.last_band    = tag_r[STAGES-1].last;
    if (tag_r[STAGES-1].has) begin
      res_data.min_value    = tag_r[STAGES-1].vmin;
      res_data.max_value    = tag_r[STAGES-1].vmax;
      res_data.top_pixel    = (row[0] < row[1]) ? row[0] : row[1];
      res_data.bottom_pixel = (row[0] < row[1]) ? row[1] : row[0];
    end else begin
      res_data.min_value    = '0;
      res_data.max_value    = '0;
      res_data.top_pixel    = '0;
      res_data.bottom_pixel = '0;
    end
  end

endmodule

@@ rtl/scd_out_q.sv @@
// Result queue seen on the output side of the block.
// Depends on scd_pkg (out_t, OUT_DEPTH); reports its fill level to scd_back.
`timescale 1ns / 1ps

module scd_out_q
  import scd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  out_t                 push_data,
  input  logic                 pop,
  output logic                 empty,
  output out_t                 head,
  output logic [OUT_CNT_W-1:0] level
);

  out_t                 mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_r, wr_nxt;
  logic [OUT_PTR_W-1:0] rd_r, rd_nxt;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_pop;

  assign empty  = (cnt_r == '0);
  assign head   = mem_r[rd_r];
  assign level  = cnt_r;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_nxt  = push   ? wr_r + OUT_PTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + OUT_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + OUT_CNT_W'(push) - OUT_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

@@ rtl/scope_minmax_column_decimator.sv @@
// Top level of the scope min/max column decimator.
// Depends on scd_pkg, scd_front, scd_snap_q, scd_back and scd_out_q.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in_     | in        | in_push / in_full    | in_data   (in_t)
//   out_    | out       | out_pop / out_empty  | out_data  (out_t)
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Cycles: the front takes one request per cycle while in_full is low; a request
//   that closes a column hands it to the column queue in the same cycle. The back
//   issues one band per cycle, when the result queue has room, into a five-stage
//   pixel pipeline.
// Stalls: in_full rises while two closed columns wait; the back issues only when
//   the result queue has room for everything already in its pipeline.
// Reset: rst_n is synchronous; it loads the register defaults and empties all
//   accumulators and queues at once, with no clearing pass.
`timescale 1ns / 1ps

module scope_minmax_column_decimator
  import scd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input request channel
  input  logic                  in_push,
  input  in_t                   in_data,
  output logic                  in_full,
  // result channel
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_t                  out_data,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // front -> column queue
  logic  snap_push;
  snap_t snap_in;
  logic  snap_full;
  // column queue -> back
  logic  snap_valid;
  logic  snap_pop;
  snap_t snap_head;
  // geometry registers live in the front, read by the back
  geom_t geom;
  // back -> result queue
  logic                 res_valid;
  out_t                 res_data;
  logic [OUT_CNT_W-1:0] out_level;

  // Front: register file, band sample select, min/max and Q16.16 column count.
  scd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .snap_full (snap_full),
    .snap_push (snap_push),
    .snap_data (snap_in),
    .geom      (geom)
  );

  // Closed columns wait here so frames keep flowing while results drain.
  scd_snap_q u_snap_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (snap_push),
    .push_data (snap_in),
    .full      (snap_full),
    .pop       (snap_pop),
    .valid     (snap_valid),
    .head      (snap_head)
  );

  // Back: per-band pixel row mapping, one band per cycle when results have room.
  scd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_head  (snap_head),
    .snap_pop   (snap_pop),
    .geom       (geom),
    .out_level  (out_level),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  // Result queue; its head is what the out_ ports show.
  scd_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (out_data),
    .level     (out_level)
  );

endmodule

@@ rtl/scd_checker.sv @@
// Port-level checks for scope_minmax_column_decimator, bound to the top level.
// Depends on scd_pkg and scope_minmax_column_decimator_defines.svh.
`timescale 1ns / 1ps
`include "scope_minmax_column_decimator_defines.svh"

module scd_checker
  import scd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_full,
  input logic out_empty,
  input logic out_pop,
  input out_t out_data
);

  logic shows_empty;
  logic shows_data;
  logic fields_zero;
  logic span_ordered;
  logic waiting;

  assign shows_empty  = !out_empty && !out_data.has_data;
  assign shows_data   = !out_empty && out_data.has_data;
  assign fields_zero  = (out_data.min_value == 16'sd0) && (out_data.max_value == 16'sd0) &&
                        (out_data.top_pixel == 12'd0) && (out_data.bottom_pixel == 12'd0);
  assign span_ordered = (out_data.min_value <= out_data.max_value) &&
                        (out_data.top_pixel <= out_data.bottom_pixel);
  assign waiting      = !out_empty && !out_pop;

  // both sides come out of reset open and empty
  `SCD_ASSERT_RESET(a_reset_clean, !in_full && out_empty, "queues not clear after reset")

  // an empty band reports nothing to draw
  `SCD_ASSERT_SAME(a_empty_band_zero, shows_empty, fields_zero, "empty band carries data")

  // span is ordered in value and in rows
  `SCD_ASSERT_SAME(a_span_order, shows_data, span_ordered, "span out of order")

  // a waiting result holds until taken
  `SCD_ASSERT_NEXT(a_result_holds, waiting, !out_empty && $stable(out_data), "waiting result changed")

endmodule

bind scope_minmax_column_decimator scd_checker u_scd_checker (.*);

@@ tb/scope_minmax_column_decimator_tb.sv @@
// Self-checking testbench for scope_minmax_column_decimator.
// Depends on scd_pkg and the RTL of the block; a scoreboard class predicts each
// column's band results, plain tasks drive the request and config ports.
`timescale 1ns / 1ps

module scope_minmax_column_decimator_tb
  import scd_pkg::*;
();

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 16;    // covers the pixel pipeline plus queue slack
  localparam int LONG_HOLD     = 400;   // one long result stall to back up the input
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 18;

  // command code the block treats as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // config index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  // ---------------------------------------------------------------------------
  // Column predictor: own copy of the registers and the min/max accumulators.
  // note_request() advances it on every accepted request and queues the band
  // results a closed column produces; check_result() pops and compares them.
  // ---------------------------------------------------------------------------
  class column_scoreboard;
    localparam longint ROW_SCALE = 819200;     // 2^15 * 25
    localparam longint ROW_DEN   = 26214400;   // 2^15 * 16 * 50
    localparam longint GAIN_NUM  = 23;         // 0.46 = 23/50

    logic [SPC_W-1:0] spc_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       modes_reg;
    logic [15:0]      lane_reg;
    logic [11:0]      image_reg;
    logic [31:0]      progress;
    int               band_lo[LANES];
    int               band_hi[LANES];
    out_t             column_q[$];
    int               errors;

    function new();
      spc_reg   = 31'd65536;
      count_reg = 3'd1;
      modes_reg = 8'd0;
      lane_reg  = 16'd2880;
      image_reg = 12'd720;
      progress  = 32'd0;
      errors    = 0;
      empty_all();
    endfunction

    function void empty_band(int b);
      band_lo[b] = 32767;
      band_hi[b] = -32768;
    endfunction

    function void empty_all();
      for (int b = 0; b < LANES; b++) empty_band(b);
    endfunction

    function int pending();
      return column_q.size();
    endfunction

    // count of 0 acts as 1, anything above the lane count saturates
    function int bands();
      int c;
      c = count_reg;
      if (c < 1) c = 1;
      if (c > LANES) c = LANES;
      return c;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      bit changed;
      changed = 1'b0;
      case (idx)
        REG_SPC: begin
          changed = spc_reg != data[SPC_W-1:0];
          spc_reg = data[SPC_W-1:0];
        end
        REG_BAND_COUNT: begin
          changed   = count_reg != data[CNT_W-1:0];
          count_reg = data[CNT_W-1:0];
        end
        REG_BAND_MODES: begin
          // only bands whose mode moved lose their samples
          for (int b = 0; b < LANES; b++)
            if (modes_reg[2*b +: 2] != data[2*b +: 2]) empty_band(b);
          modes_reg = data[7:0];
        end
        REG_LANE_HEIGHT: begin
          changed  = lane_reg != data[15:0];
          lane_reg = data[15:0];
        end
        REG_IMAGE_HEIGHT: begin
          changed   = image_reg != data[11:0];
          image_reg = data[11:0];
        end
        default: ;
      endcase
      if (changed) begin
        progress = 32'd0;
        empty_all();
      end
    endfunction

    function void band_pair(in_t r, int b, output int l, output int rt);
      case (b)
        0: begin l = r.left_0; rt = r.right_0; end
        1: begin l = r.left_1; rt = r.right_1; end
        2: begin l = r.left_2; rt = r.right_2; end
        default: begin l = r.left_3; rt = r.right_3; end
      endcase
    endfunction

    function int shown(int b, int l, int rt);
      case (mode_t'(modes_reg[2*b +: 2]))
        MODE_LEFT:  return l;
        MODE_RIGHT: return rt;
        MODE_MID:   return (l + rt) >>> 1;
        default:    return (l - rt) >>> 1;
      endcase
    endfunction

    // lane center minus scaled value, rounded half up, clamped to the image
    function int pixel_row(int b, int v);
      longint amp, num, row, hmax;
      amp  = longint'(lane_reg) - 224;
      if (amp < 0) amp = 0;
      hmax = (image_reg == 12'd0) ? 0 : longint'(image_reg) - 1;
      num  = longint'(lane_reg) * longint'(2 * b + 1) * ROW_SCALE
           - longint'(v) * amp * GAIN_NUM;
      if (num < 0) return 0;
      row = (num + ROW_DEN / 2) / ROW_DEN;
      if (row > hmax) row = hmax;
      return int'(row);
    endfunction

    function void note_request(in_t r);
      int n, l, rt, s, t, u;
      logic [31:0] eff;
      out_t e;
      n = bands();
      case (r.cmd)
        CMD_CLEAR_BAND: begin
          if (int'(r.band_select) < n) empty_band(r.band_select);
          return;
        end
        CMD_RESET_ALL: begin
          progress = 32'd0;
          empty_all();
          return;
        end
        CMD_SAMPLE: ;
        default: return;
      endcase
      for (int b = 0; b < n; b++) begin
        band_pair(r, b, l, rt);
        s = shown(b, l, rt);
        if (s < band_lo[b]) band_lo[b] = s;
        if (s > band_hi[b]) band_hi[b] = s;
      end
      eff = (spc_reg < 31'd65536) ? ONE_Q16 : {1'b0, spc_reg};
      progress = progress + ONE_Q16;
      if (progress < eff) return;
      progress = progress - eff;
      for (int b = 0; b < n; b++) begin
        e = '0;
        e.out_band  = b[1:0];
        e.last_band = (b + 1 == n);
        if (band_lo[b] <= band_hi[b]) begin
          t = pixel_row(b, band_hi[b]);
          u = pixel_row(b, band_lo[b]);
          e.has_data     = 1'b1;
          e.min_value    = band_lo[b][15:0];
          e.max_value    = band_hi[b][15:0];
          e.top_pixel    = (t < u) ? t[11:0] : u[11:0];
          e.bottom_pixel = (t < u) ? u[11:0] : t[11:0];
        end
        column_q.push_back(e);
      end
      empty_all();
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (column_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %p", $time, got);
        return;
      end
      want = column_q.pop_front();
      compare("out_band", want.out_band, got.out_band);
      compare("has_data", want.has_data, got.has_data);
      compare("min_value", want.min_value, got.min_value);
      compare("max_value", want.max_value, got.max_value);
      compare("top_pixel", want.top_pixel, got.top_pixel);
      compare("bottom_pixel", want.bottom_pixel, got.bottom_pixel);
      compare("last_band", want.last_band, got.last_band);
    endfunction

    function void report_leftovers();
      foreach (column_q[i]) begin
        errors++;
        $display("%0t missing result: expected %p actual none", $time, column_q[i]);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  in_t                   in_data;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scope_minmax_column_decimator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  column_scoreboard sb;
  int unsigned      cycle_count;
  bit               hold_request;  // main asks the result side for its long stall
  bit               tx_steady;     // sender runs without gaps this phase
  bit               rx_steady;     // receiver pops without gaps for a while

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitor: values read at the edge are the pre-edge ones, so a handshake seen
  // here is exactly the one the DUT takes. Results go first; a request accepted
  // on the same edge cannot have produced a result yet.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) sb.check_result(out_data);
      if (in_push && !in_full)   sb.note_request(in_data);
    end
  end

  // Result side: random pop gaps, steady stretches, and one long hold-off that
  // lets the result queue and column queue fill so in_full must rise.
  initial begin
    int gap, taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = rx_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      taken++;
      if (taken % 24 == 0) rx_steady = ($urandom_range(0, 2) == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Request and config drivers
  // ---------------------------------------------------------------------------

  // Offer one request; push stays high on return so a zero gap is back to back.
  task automatic send(in_t req);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_full);
  endtask

  // Stop offering, drain every predicted result, then let any request that
  // produced nothing clear the pipeline before the config may change.
  task automatic settle();
    in_push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid stays up when another write follows right away.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data,
                         bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic load_setup(logic [SPC_W-1:0] spc, logic [CNT_W-1:0] count,
                            logic [7:0] modes, logic [15:0] lane, logic [11:0] image);
    set_reg(REG_SPC, CFG_DATA_W'(spc), 1'b1);
    set_reg(REG_BAND_COUNT, CFG_DATA_W'(count), 1'b1);
    set_reg(REG_BAND_MODES, CFG_DATA_W'(modes), 1'b1);
    set_reg(REG_LANE_HEIGHT, CFG_DATA_W'(lane), 1'b1);
    set_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(image), 1'b0);
  endtask

  // Same left/right pair on every band.
  function automatic in_t make_req(logic [1:0] cmd, logic [1:0] sel,
                                   logic [15:0] l, logic [15:0] r);
    in_t q;
    q.cmd = cmd;
    q.band_select = sel;
    q.left_0 = l;  q.right_0 = r;
    q.left_1 = l;  q.right_1 = r;
    q.left_2 = l;  q.right_2 = r;
    q.left_3 = l;  q.right_3 = r;
    return q;
  endfunction

  // Full-scale values show up often so clamps and mid/side corners get hit.
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly sample frames; the rest clears, resets and the unused code.
  function automatic in_t rand_request();
    in_t q;
    int roll;
    roll = $urandom_range(0, 99);
    q.left_0 = rand_sample();  q.right_0 = rand_sample();
    q.left_1 = rand_sample();  q.right_1 = rand_sample();
    q.left_2 = rand_sample();  q.right_2 = rand_sample();
    q.left_3 = rand_sample();  q.right_3 = rand_sample();
    q.band_select = 2'($urandom_range(0, 3));
    if (roll < 84)      q.cmd = CMD_SAMPLE;
    else if (roll < 91) q.cmd = CMD_CLEAR_BAND;
    else if (roll < 96) q.cmd = CMD_RESET_ALL;
    else                q.cmd = CMD_UNUSED;
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [SPC_W-1:0] spc;
    logic [15:0]      lane;
    logic [11:0]      image;

    sb           = new();
    hold_request = 1'b0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: one band, left channel, a column per request.
    send(make_req(CMD_SAMPLE, 2'd0, 16'h7FFF, 16'h7FFF));
    send(make_req(CMD_SAMPLE, 2'd0, 16'h8000, 16'h8000));
    settle();

    // Four bands, one of each mode, three requests per column.
    load_setup(31'(3 * 65536), 3'd4, {MODE_SIDE, MODE_MID, MODE_RIGHT, MODE_LEFT},
               16'd2880, 12'd720);
    send(make_req(CMD_SAMPLE, 2'd0, 16'h7FFF, 16'h8000));   // side at its top
    send(make_req(CMD_SAMPLE, 2'd3, 16'h8000, 16'h7FFF));   // side at its bottom
    send(make_req(CMD_CLEAR_BAND, 2'd2, 16'h1234, 16'h4321));
    send(make_req(CMD_SAMPLE, 2'd1, 16'h8000, 16'h8000));   // closes the column
    send(make_req(CMD_UNUSED, 2'd1, 16'h7FFF, 16'h7FFF));
    send(rand_request());
    send(make_req(CMD_RESET_ALL, 2'd0, 16'h0000, 16'h0000));
    send(make_req(CMD_SAMPLE, 2'd0, 16'h0001, 16'hFFFF));
    send(make_req(CMD_CLEAR_BAND, 2'd3, 16'h0000, 16'h0000));
    send(make_req(CMD_SAMPLE, 2'd2, 16'h4000, 16'hC000));
    send(make_req(CMD_SAMPLE, 2'd1, 16'hFFFF, 16'h0001));
    settle();

    // Degenerate settings: count 0, zero lane and image, rate below one.
    load_setup(31'd1, 3'd0, 8'h55, 16'd0, 12'd0);
    set_reg(REG_NONE, 31'h7FFF_FFFF, 1'b0);
    send(make_req(CMD_CLEAR_BAND, 2'd3, 16'h7FFF, 16'h8000));  // beyond count
    send(make_req(CMD_CLEAR_BAND, 2'd0, 16'h7FFF, 16'h8000));
    send(make_req(CMD_SAMPLE, 2'd0, 16'h7FFF, 16'h8000));
    send(make_req(CMD_SAMPLE, 2'd3, 16'h8000, 16'h7FFF));
    settle();

    // Top extremes: count saturates, tallest lane and image.
    load_setup(31'd65536, 3'd7, 8'h1B, 16'hFFFF, 12'd4095);
    send(make_req(CMD_SAMPLE, 2'd0, 16'h7FFF, 16'h8000));
    send(make_req(CMD_SAMPLE, 2'd0, 16'h0000, 16'h0000));
    send(rand_request());
    settle();

    // Random phases, each under a fresh setup.
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       spc = 31'd0;
        1:       spc = 31'($urandom_range(1, 65535));
        default: spc = 31'(65536 + $urandom_range(0, 3 * 65536));
      endcase
      case ($urandom_range(0, 5))
        0:       lane = 16'd0;
        1:       lane = 16'hFFFF;
        2:       lane = 16'd224;
        default: lane = 16'($urandom_range(225, 4000));
      endcase
      case ($urandom_range(0, 5))
        0:       image = 12'd0;
        1:       image = 12'd1;
        2:       image = 12'd4095;
        default: image = 12'($urandom_range(200, 1200));
      endcase
      if (ph == 3) spc = 31'h7FFF_FFFF;   // slowest rate: no column closes
      if (ph == 0) begin
        // every request closes a four-band column while the receiver holds off
        load_setup(31'd65536, 3'd4, 8'($urandom), lane, image);
        hold_request = 1'b1;
      end else begin
        load_setup(spc, 3'($urandom_range(0, 7)), 8'($urandom), lane, image);
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) send(rand_request());
      settle();
    end

    sb.report_leftovers();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
